>>> rtl/euclidean_distance_matrix_3d_assert.svh
// assertion macros for the distance matrix block
`ifndef EUCLIDEAN_DISTANCE_MATRIX_3D_ASSERT_SVH
`define EUCLIDEAN_DISTANCE_MATRIX_3D_ASSERT_SVH

// same-cycle implication, checked on every clock edge out of reset
`define EDM3D_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define EDM3D_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/edm3d_pkg.sv
// shared types and constants for the distance matrix block
`timescale 1ns / 1ps

package edm3d_pkg;

   localparam int IDX_W          = 6;
   localparam int DIST_W         = 17;
   localparam int COL_W          = 6;
   localparam int NODE_COUNT_W   = 7;
   localparam int NODE_COUNT_RST = 64;

   localparam logic CMD_STORE = 1'b0;
   localparam logic CMD_ROW   = 1'b1;

   typedef struct packed {
      logic busy;
      logic done;
   } sqrt_status_type;

endpackage

>>> rtl/euclidean_distance_matrix_3d.sv
// Pairwise 3D Euclidean distance engine over a stored point table. A store
// request writes one point into the table. A row request streams
// min(node_count, MAX_NODES) distances, each the floor square root of the
// squared distance, with tlast on the final one. Distances are worked one
// after another through the square root unit, which produces one root bit
// per cycle; a finished distance waits while the previous distance still
// waits in the output register.
// One request is worked at a time; req_tready is low while a row runs.
// Reading a point that was never stored gives an undefined distance.
`timescale 1ns / 1ps

module euclidean_distance_matrix_3d
   import edm3d_pkg::*;
#(
   parameter int MAX_NODES  = 64,
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   // point_index, coord_x, coord_y, coord_z, zero pad
   input  logic [((IDX_W+3*COORD_BITS+7)/8)*8-1:0] req_tdata,
   // command
   input  logic                         req_tuser,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // distance, column_index, zero pad
   output logic [23:0]                  rsp_tdata,
   output logic                         rsp_tlast,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   input  logic                         csr_wr_en,
   input  logic [NODE_COUNT_W-1:0]      csr_wr_data
);

   localparam int ADDR_W  = $clog2(MAX_NODES);
   localparam int PT_W    = 3 * COORD_BITS;
   localparam int SQ_W    = 2 * COORD_BITS;
   localparam int SUM_W   = (2 * COORD_BITS + 2 > 64) ? 64 : 2 * COORD_BITS + 2;
   localparam int ROOT_W  = SUM_W / 2;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ROW   = 3'd1;
   localparam logic [2:0] S_FETCH = 3'd2;
   localparam logic [2:0] S_SQR   = 3'd3;
   localparam logic [2:0] S_ADD   = 3'd4;
   localparam logic [2:0] S_ROOT  = 3'd5;
   localparam logic [2:0] S_EMIT  = 3'd6;

   logic [2:0]              state_ff, state_in;
   logic [NODE_COUNT_W-1:0] node_count_ff, node_count_in;
   logic [NODE_COUNT_W-1:0] count_ff, count_in;
   logic [NODE_COUNT_W-1:0] col_ff, col_in;
   logic [1:0]              axis_ff, axis_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic [PT_W-1:0]         point_store_mem [MAX_NODES];
   logic [PT_W-1:0]         rd_data_ff;
   logic [PT_W-1:0]         row_ff;
   logic [SQ_W-1:0]         prod_ff;
   logic [SUM_W-1:0]        sum_ff;
   logic [DIST_W-1:0]       dist_ff;
   logic [COL_W-1:0]        col_out_ff;
   logic                    last_ff;

   logic [IDX_W-1:0]        req_point_index;
   logic                    req_fire;
   logic                    idx_ok;
   logic                    mem_we;
   logic [ADDR_W-1:0]       rd_addr;
   logic [NODE_COUNT_W-1:0] count_eff;
   logic                    row_last;
   logic                    rsp_load;

   logic signed [COORD_BITS-1:0] coord_a, coord_b;
   logic signed [COORD_BITS:0]   diff_s;
   logic [COORD_BITS-1:0]        diff;

   logic                    sq_start;
   sqrt_status_type         sq_status;
   logic [ROOT_W-1:0]       sq_root;
   logic [ROOT_W+DIST_W-1:0] root_ext;

   assign req_point_index = req_tdata[IDX_W-1:0];
   assign req_tready      = (state_ff == S_IDLE);
   assign req_fire        = req_tvalid && req_tready;
   assign idx_ok          = (32'(req_point_index) < 32'(MAX_NODES));
   assign mem_we          = req_fire && idx_ok && (req_tuser == CMD_STORE);
   assign rd_addr         = (state_ff == S_IDLE) ? ADDR_W'(req_point_index)
                                                 : ADDR_W'(col_ff);
   assign count_eff       = (32'(node_count_ff) > 32'(MAX_NODES))
                            ? NODE_COUNT_W'(MAX_NODES) : node_count_ff;
   assign row_last        = (col_ff == count_ff - NODE_COUNT_W'(1));
   assign rsp_load        = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_tready);

   // absolute coordinate difference on the current axis
   assign coord_a = row_ff[axis_ff*COORD_BITS +: COORD_BITS];
   assign coord_b = rd_data_ff[axis_ff*COORD_BITS +: COORD_BITS];
   assign diff_s  = (coord_a >= coord_b)
                    ? ({coord_a[COORD_BITS-1], coord_a} - {coord_b[COORD_BITS-1], coord_b})
                    : ({coord_b[COORD_BITS-1], coord_b} - {coord_a[COORD_BITS-1], coord_a});
   assign diff    = diff_s[COORD_BITS-1:0];

   assign sq_start = (state_ff == S_ADD);
   assign root_ext = {{DIST_W{1'b0}}, sq_root};

   edm3d_sqrt #(
      .SUM_W (SUM_W)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sum_ff + SUM_W'(prod_ff)),
      .status   (sq_status),
      .root     (sq_root)
   );

   always_comb begin
      state_in      = state_ff;
      node_count_in = node_count_ff;
      count_in      = count_ff;
      col_in        = col_ff;
      axis_in       = axis_ff;
      rsp_valid_in  = rsp_valid_ff;

      if (csr_wr_en) begin
         node_count_in = csr_wr_data;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && idx_ok && (req_tuser == CMD_ROW) &&
                (count_eff != '0)) begin
               count_in = count_eff;
               col_in   = '0;
               state_in = S_ROW;
            end
         end
         S_ROW: begin
            axis_in  = 2'd0;
            state_in = S_SQR;
         end
         S_FETCH: begin
            axis_in  = 2'd0;
            state_in = S_SQR;
         end
         S_SQR: begin
            axis_in = axis_ff + 2'd1;
            if (axis_ff == 2'd2) begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            state_in = S_ROOT;
         end
         S_ROOT: begin
            if (sq_status.done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (rsp_load) begin
               if (row_last) begin
                  state_in = S_IDLE;
               end else begin
                  col_in   = col_ff + NODE_COUNT_W'(1);
                  state_in = S_FETCH;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         node_count_ff <= NODE_COUNT_W'(NODE_COUNT_RST);
         count_ff      <= '0;
         col_ff        <= '0;
         axis_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_count_ff <= node_count_in;
         count_ff      <= count_in;
         col_ff        <= col_in;
         axis_ff       <= axis_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // point table, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         point_store_mem[ADDR_W'(req_point_index)] <= req_tdata[IDX_W +: PT_W];
      end
      rd_data_ff <= point_store_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_ROW) begin
         row_ff <= rd_data_ff;
      end
      if (state_ff == S_SQR) begin
         prod_ff <= SQ_W'(diff) * SQ_W'(diff);
         // first axis clears the sum, which then adds the product registered for the previous axis
         sum_ff  <= (axis_ff == 2'd0) ? '0 : sum_ff + SUM_W'(prod_ff);
      end
      if (rsp_load) begin
         dist_ff    <= root_ext[DIST_W-1:0];
         col_out_ff <= col_ff[COL_W-1:0];
         last_ff    <= row_last;
      end
   end

   assign rsp_tdata  = {1'b0, col_out_ff, dist_ff};
   assign rsp_tlast  = last_ff;
   assign rsp_tvalid = rsp_valid_ff;

   `include "euclidean_distance_matrix_3d_assert.svh"

   `EDM3D_ASSERT_NEXT(a_last_ends_row, rsp_load && row_last, state_ff == S_IDLE, "row did not end after last result")
   `EDM3D_ASSERT_NOW(a_col_in_range, state_ff != S_IDLE, col_ff < count_ff, "column counter beyond row length")
   `EDM3D_ASSERT_NOW(a_start_when_free, sq_start, !sq_status.busy, "square root started while busy")
   `EDM3D_ASSERT_NOW(a_done_in_root, sq_status.done, state_ff == S_ROOT, "root finished outside root wait")

endmodule

>>> rtl/edm3d_sqrt.sv
// iterative integer square root, one result bit per cycle
`timescale 1ns / 1ps

module edm3d_sqrt
   import edm3d_pkg::*;
#(
   parameter int SUM_W = 34
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [SUM_W-1:0]     radicand,
   output sqrt_status_type      status,
   output logic [SUM_W/2-1:0]   root
);

   localparam int ROOT_W = SUM_W / 2;
   localparam int CNT_W  = $clog2(ROOT_W + 1);

   logic [SUM_W-1:0]  rad_ff, rad_in;
   logic [ROOT_W+1:0] rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [ROOT_W+1:0] rem_sh;
   logic [ROOT_W+1:0] trial;
   logic              fits;

   // bring down the next two radicand bits and try the next root bit
   assign rem_sh = {rem_ff[ROOT_W-1:0], rad_ff[SUM_W-1 -: 2]};
   assign trial  = {root_ff, 2'b01};
   assign fits   = (rem_sh >= trial);

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(ROOT_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[SUM_W-3:0], 2'b00};
         rem_in  = fits ? (rem_sh - trial) : rem_sh;
         root_in = {root_ff[ROOT_W-2:0], fits};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign root        = root_ff;

endmodule

>>> verif/tb.sv
// testbench for the 3d euclidean distance matrix block
`timescale 1ns / 1ps

module tb;
   import edm3d_pkg::*;

   localparam int TABLE_DEPTH   = 64;
   localparam int COORD_W       = 16;
   localparam int REQ_W         = ((IDX_W + 3*COORD_W + 7)/8)*8;
   localparam int SETTLE_CYCLES = 64;
   localparam int CYCLE_LIMIT   = 2000000;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic [COL_W-1:0]  column;
      logic              last;
   } distance_entry_type;

   logic                    clock;
   logic                    reset       = 1'b1;
   // point_index, coord_x, coord_y, coord_z, zero pad
   logic [REQ_W-1:0]        req_tdata   = '0;
   // command
   logic                    req_tuser   = 1'b0;
   logic                    req_tvalid  = 1'b0;
   logic                    req_tready;
   // distance, column_index, zero pad
   logic [23:0]             rsp_tdata;
   logic                    rsp_tlast;
   logic                    rsp_tvalid;
   logic                    rsp_tready  = 1'b0;
   logic                    csr_wr_en   = 1'b0;
   logic [NODE_COUNT_W-1:0] csr_wr_data = '0;

   // predictor state
   coord_type               table_x [TABLE_DEPTH];
   coord_type               table_y [TABLE_DEPTH];
   coord_type               table_z [TABLE_DEPTH];
   logic [NODE_COUNT_W-1:0] node_count_reg = NODE_COUNT_W'(NODE_COUNT_RST);
   distance_entry_type      pending_distances [$];

   bit src_idle  = 1'b1;
   bit sink_idle = 1'b1;
   int error_count       = 0;
   int stores_sent       = 0;
   int rows_sent         = 0;
   int distances_checked = 0;
   int cycle_count       = 0;

   euclidean_distance_matrix_3d #(
      .MAX_NODES  (TABLE_DEPTH),
      .COORD_BITS (COORD_W)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d distances still pending",
                  cycle_count, pending_distances.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= 10)
         $display("mismatch: %s", what);
   endtask

   // largest root whose square does not exceed the sum, one bit at a time
   function automatic logic [DIST_W-1:0] floor_root(input logic [63:0] sum);
      logic [DIST_W-1:0] root;
      logic [DIST_W-1:0] trial;
      root = '0;
      for (int b = DIST_W-1; b >= 0; b--) begin
         trial = root | (DIST_W'(1) << b);
         if ({47'd0, trial} * {47'd0, trial} <= sum)
            root = trial;
      end
      return root;
   endfunction

   function automatic logic [DIST_W-1:0] point_gap(input int a, input int b);
      longint dx;
      longint dy;
      longint dz;
      dx = longint'(table_x[a]) - longint'(table_x[b]);
      dy = longint'(table_y[a]) - longint'(table_y[b]);
      dz = longint'(table_z[a]) - longint'(table_z[b]);
      return floor_root(64'(dx*dx + dy*dy + dz*dz));
   endfunction

   task automatic predict_request(input logic cmd, input logic [IDX_W-1:0] idx,
                                  input coord_type x, input coord_type y,
                                  input coord_type z);
      int cols;
      distance_entry_type entry;
      if (cmd == CMD_STORE) begin
         table_x[idx] = x;
         table_y[idx] = y;
         table_z[idx] = z;
         stores_sent++;
      end else begin
         cols = (node_count_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(node_count_reg);
         for (int c = 0; c < cols; c++) begin
            entry.distance = point_gap(idx, c);
            entry.column   = COL_W'(c);
            entry.last     = (c == cols - 1);
            pending_distances.insert(pending_distances.size(), entry);
         end
         rows_sent++;
      end
   endtask

   // valid stays high from one request to the next when there is no gap
   task automatic send_request(input logic cmd, input logic [IDX_W-1:0] idx,
                               input coord_type x = '0, input coord_type y = '0,
                               input coord_type z = '0);
      int gap;
      gap = src_idle ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tuser  <= cmd;
      req_tdata  <= {{(REQ_W-IDX_W-3*COORD_W){1'b0}}, z, y, x, idx};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predict_request(cmd, idx, x, y, z);
   endtask

   // wait for every distance, then for the block to go idle
   task automatic finish_phase();
      req_tvalid <= 1'b0;
      while (pending_distances.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_node_count(input logic [NODE_COUNT_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      node_count_reg = value;
   endtask

   function automatic coord_type pick_coord();
      case ($urandom_range(0, 7))
         0:       return 16'sh7fff;
         1:       return 16'sh8000;
         2:       return '0;
         3:       return coord_type'($urandom_range(0, 15)) - 16'sd8;
         default: return coord_type'($urandom);
      endcase
   endfunction

   // response sink: checks each distance against the oldest prediction
   always @(posedge clock) begin : rsp_sink
      int stall;
      distance_entry_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall = 0;
      end else if (rsp_tvalid && rsp_tready) begin
         if (pending_distances.size() == 0) begin
            report_mismatch($sformatf("unexpected distance %0d column %0d last %0b",
                            rsp_tdata[DIST_W-1:0], rsp_tdata[DIST_W +: COL_W], rsp_tlast));
         end else begin
            want = pending_distances.pop_front();
            if (rsp_tdata[DIST_W-1:0] !== want.distance ||
                rsp_tdata[DIST_W +: COL_W] !== want.column || rsp_tlast !== want.last)
               report_mismatch($sformatf(
                  "expected dist %0d col %0d last %0b, got dist %0d col %0d last %0b",
                  want.distance, want.column, want.last, rsp_tdata[DIST_W-1:0],
                  rsp_tdata[DIST_W +: COL_W], rsp_tlast));
            distances_checked++;
         end
         stall = sink_idle ? $urandom_range(0, 6) : 0;
         rsp_tready <= (stall == 0);
      end else if (!rsp_tready) begin
         if (stall <= 1) begin
            rsp_tready <= 1'b1;
            stall = 0;
         end else begin
            stall = stall - 1;
         end
      end
   end

   // corners of the coordinate range, including the largest possible distance
   task automatic test_small_table();
      src_idle  = 1'b1;
      sink_idle = 1'b1;
      set_node_count(4);
      send_request(CMD_STORE, 0, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_request(CMD_STORE, 1, 16'sh8000, 16'sh8000, 16'sh8000);
      send_request(CMD_STORE, 2, 16'sh0000, 16'sh0000, 16'sh0000);
      send_request(CMD_STORE, 3, -16'sd1, 16'sh7fff, 16'sh8000);
      send_request(CMD_ROW, 3);
      send_request(CMD_ROW, 0);
      send_request(CMD_ROW, 2);
      send_request(CMD_ROW, 1);
      finish_phase();
   endtask

   // a row with zero node count gives nothing, a single column row is all last
   task automatic test_degenerate_rows();
      set_node_count(0);
      send_request(CMD_ROW, 1);
      send_request(CMD_STORE, 2, 16'sd3, -16'sd4, 16'sd12);
      send_request(CMD_ROW, 0);
      finish_phase();
      set_node_count(1);
      send_request(CMD_ROW, 3);
      send_request(CMD_ROW, 0);
      send_request(CMD_ROW, 2);
      finish_phase();
   endtask

   task automatic test_fill_table();
      src_idle = 1'b0;
      for (int i = 0; i < TABLE_DEPTH; i++)
         send_request(CMD_STORE, IDX_W'(i), pick_coord(), pick_coord(), pick_coord());
      finish_phase();
   endtask

   // full table and counts above the table size that must saturate
   task automatic test_full_rows();
      src_idle  = 1'b0;
      sink_idle = 1'b0;
      set_node_count(64);
      send_request(CMD_ROW, 63);
      send_request(CMD_ROW, 0);
      finish_phase();
      set_node_count(127);
      send_request(CMD_ROW, 31);
      finish_phase();
      sink_idle = 1'b1;
      set_node_count(65);
      send_request(CMD_ROW, 42);
      finish_phase();
   endtask

   task automatic test_random_traffic();
      logic [NODE_COUNT_W-1:0] counts [10] = '{7'd2, 7'd7, 7'd64, 7'd1, 7'd0,
                                               7'd127, 7'd13, 7'd3, 7'd96, 7'd5};
      int n_items;
      for (int p = 0; p < 10; p++) begin
         src_idle  = ($urandom_range(0, 3) != 0);
         sink_idle = ($urandom_range(0, 3) != 0);
         set_node_count(counts[p]);
         n_items = (counts[p] >= TABLE_DEPTH) ? 6 : 24;
         for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 99) < 35)
               send_request(CMD_STORE, IDX_W'($urandom_range(0, TABLE_DEPTH-1)),
                            pick_coord(), pick_coord(), pick_coord());
            else
               send_request(CMD_ROW, IDX_W'($urandom_range(0, TABLE_DEPTH-1)));
         end
         finish_phase();
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_small_table();
      test_degenerate_rows();
      test_fill_table();
      test_full_rows();
      test_random_traffic();
      $display("covered %0d point stores and %0d row requests, %0d distances checked",
               stores_sent, rows_sent, distances_checked);
      $display("node counts from 0 to 127, coordinate extremes, random stalls on both sides");
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/edm3d_pkg.sv
rtl/edm3d_sqrt.sv
rtl/euclidean_distance_matrix_3d.sv
verif/tb.sv
